### design/ttl_pkg.sv
// Shared types, fixed-point constants and helpers for the tilt-to-lift block.
// Used by ttl_mul, ttl_sqrt and tilt_to_lift_motor_targets.
package ttl_pkg;

	localparam int FRAC_BITS = 24;
	localparam int MUL_W     = 32;
	localparam int SQRT_W    = 58;
	localparam int ROOT_W    = SQRT_W / 2;
	localparam int CFG_IDX_W = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_INCH = 3'd4;

	// Register reset values
	localparam logic [15:0] HEIGHT_MAX_RST = 16'd19000;
	localparam logic [15:0] HEIGHT_MIN_RST = 16'd2600;
	localparam logic [11:0] HEIGHT_STEP_RST = 12'd100;
	localparam logic [15:0] SILENCE_RST    = 16'd40;
	localparam logic [15:0] CPI_RST        = 16'd1829;

	// Lift commands
	localparam logic signed [1:0] CMD_LOWER = -2'sd1;
	localparam logic signed [1:0] CMD_RAISE = 2'sd1;

	// Fixed-point constants, 24 fractional bits, truncated
	localparam logic [27:0] C_322   = 28'd54022635;   // 3.22
	localparam logic [32:0] C_BY2   = 33'd4777574400; // 16.875 squared
	localparam logic [28:0] C_REST  = 29'd271520249;  // 16.183868
	localparam logic [24:0] C_ONE   = 25'd16777216;   // 1.0
	localparam logic signed [21:0] N_SAT = 22'sd4096;

	typedef enum logic [3:0] {
		ST_IDLE, ST_N, ST_NSQ, ST_SQ1, ST_SQ1W, ST_T, ST_SQ2, ST_SQ2W, ST_P, ST_OUT
	} st_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	// Nut offset then saturate to the 18-bit target range
	function automatic logic signed [17:0] to_target(input logic signed [27:0] s);
		logic signed [27:0] v;
		v = (s > 28'sd0) ? s - 28'sd1 : s;
		if (v > 28'sd131071)
			to_target = 18'sd131071;
		else if (v < -28'sd131072)
			to_target = -18'sd131072;
		else
			to_target = v[17:0];
	endfunction

endpackage

### design/tilt_to_lift_motor_targets.sv
// Tilt-to-lift motor targets: one word in, four motor targets out.
// Each axis runs two 29-step roots on the shared root unit plus its sequencer states;
// a saturated tilt skips its first root. The x axis runs first, then the y axis.
// One word at a time: the next word is taken only in ST_IDLE; ST_OUT stalls while full.
// Asynchronous active-low reset restores register defaults, no offset taken.
module tilt_to_lift_motor_targets (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [ttl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // x_accel[15:0], y_accel[31:16], lift_command[33:32], zeros
	input  logic        s_tuser,  // sample_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // motor_a, motor_b, motor_c, motor_d, 18 bits each
);
	import ttl_pkg::*;

	st_t state_q, state_d;

	logic [15:0] hmax_q, hmin_q, silence_lim_q, cpi_q;
	logic [11:0] hstep_q;
	logic signed [15:0] lx_q, ly_q, ox_q, oy_q;
	logic signed [1:0]  cmd_q;
	logic        started_q;
	logic [15:0] sil_q;
	logic [15:0] height_q;
	logic        zero_q, ax_q, neg1_q;
	logic signed [21:0] n_q;
	logic [24:0] s_q;
	logic signed [28:0] a8_q;
	logic signed [25:0] dx_q, dy_q;
	logic [71:0] out_q;
	logic        out_v_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_q;
	logic              sq_start;
	logic [SQRT_W-1:0] sq_rad;
	sqrt_stat_t        sq_stat;
	logic [ROOT_W-1:0] sq_root;

	logic signed [16:0] d_ax;
	logic signed [28:0] t_v;
	logic [26:0]        mag_v;
	logic [29:0]        t2_v;
	logic [32:0]        rad2_v;
	logic [24:0]        rad1_v;
	logic signed [30:0] dyv;
	logic [17:0]        k3;
	logic [63:0]        pmag;
	logic signed [25:0] del_v;
	logic               sat_hi, sat_lo;
	logic signed [27:0] h_ext;
	logic signed [17:0] nh;
	logic [15:0]        nh_c;
	logic [16:0]        sil_n;
	logic               started_n;

	ttl_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_q(prod_q));

	ttl_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_rad),
		.stat(sq_stat), .root(sq_root)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Axis datapath terms
	always_comb begin
		d_ax   = ax_q ? (17'(oy_q) - 17'(ly_q)) : (17'(lx_q) - 17'(ox_q));
		sat_hi = (n_q >= N_SAT);
		sat_lo = (n_q <= -N_SAT);
		rad1_v = C_ONE - prod_q[24:0];
		t_v    = $signed({1'b0, C_322}) - $signed({1'b0, s_q, 3'b000});
		mag_v  = t_v[28] ? 27'(-t_v) : t_v[26:0];
		t2_v   = prod_q[53:24];
		rad2_v = C_BY2 - 33'(t2_v);
		dyv    = $signed({2'b00, sq_root}) - 31'(a8_q) - $signed({2'b00, C_REST});
		k3     = {1'b0, cpi_q, 1'b0} + {2'b00, cpi_q};
		pmag   = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
		del_v  = prod_q[63] ? -$signed({1'b0, pmag[48:24]}) : $signed({1'b0, pmag[48:24]});
		if (neg1_q)
			del_v = -del_v;
		h_ext  = $signed({12'd0, height_q});
	end

	// Height step and clamps, max first
	always_comb begin
		nh = $signed({2'b00, height_q});
		if (cmd_q == CMD_LOWER)
			nh = nh - $signed({6'd0, hstep_q});
		else if (cmd_q == CMD_RAISE)
			nh = nh + $signed({6'd0, hstep_q});
		if (nh > $signed({2'b00, hmax_q}))
			nh = $signed({2'b00, hmax_q});
		if (nh < $signed({2'b00, hmin_q}))
			nh = $signed({2'b00, hmin_q});
		nh_c = nh[15:0];
	end

	// Silence count as it stands after this word
	always_comb begin
		started_n = started_q | s_tuser;
		if (s_tuser)
			sil_n = '0;
		else if (started_q && sil_q != 16'hFFFF)
			sil_n = {1'b0, sil_q} + 17'd1;
		else
			sil_n = {1'b0, sil_q};
	end

	// Sequencer: next state and shared unit operands
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		sq_rad   = '0;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_N;
			ST_N: begin
				mul_a   = MUL_W'(d_ax);
				mul_b   = 32'sd25;
				state_d = ST_NSQ;
			end
			ST_NSQ: begin
				mul_a   = MUL_W'(prod_q[21:0]);
				mul_b   = MUL_W'(prod_q[21:0]);
				mul_a   = $signed({{10{prod_q[21]}}, prod_q[21:0]});
				mul_b   = mul_a;
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				if (sat_hi || sat_lo) begin
					state_d = ST_T;
				end else begin
					sq_start = 1'b1;
					sq_rad   = {9'd0, rad1_v, 24'd0};
					state_d  = ST_SQ1W;
				end
			end
			ST_SQ1W: if (sq_stat.done) state_d = ST_T;
			ST_T: begin
				mul_a   = $signed({5'd0, mag_v});
				mul_b   = $signed({5'd0, mag_v});
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				sq_start = 1'b1;
				sq_rad   = {1'b0, rad2_v, 24'd0};
				state_d  = ST_SQ2W;
			end
			ST_SQ2W: begin
				mul_a = $signed({dyv[30], dyv});
				mul_b = $signed({14'd0, k3});
				if (sq_stat.done)
					state_d = ST_P;
			end
			ST_P: state_d = ax_q ? ST_OUT : ST_N;
			ST_OUT: if (!out_v_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmax_q        <= HEIGHT_MAX_RST;
			hmin_q        <= HEIGHT_MIN_RST;
			hstep_q       <= HEIGHT_STEP_RST;
			silence_lim_q <= SILENCE_RST;
			cpi_q         <= CPI_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEIGHT_MAX:      hmax_q        <= cfg_data;
				REG_HEIGHT_MIN:      hmin_q        <= cfg_data;
				REG_HEIGHT_STEP:     hstep_q       <= cfg_data[11:0];
				REG_SILENCE_LIMIT:   silence_lim_q <= cfg_data;
				REG_COUNTS_PER_INCH: cpi_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tick state: stored sample, offset, silence, height, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q      <= '0;
			ly_q      <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			cmd_q     <= '0;
			started_q <= 1'b0;
			sil_q     <= '0;
			height_q  <= HEIGHT_MIN_RST;
			zero_q    <= 1'b1;
			ax_q      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && s_tvalid) begin
				if (s_tuser) begin
					lx_q  <= $signed(s_tdata[15:0]);
					ly_q  <= $signed(s_tdata[31:16]);
					cmd_q <= $signed(s_tdata[33:32]);
					if (!started_q) begin
						ox_q <= $signed(s_tdata[15:0]);
						oy_q <= $signed(s_tdata[31:16]);
					end
				end
				started_q <= started_n;
				sil_q     <= sil_n[15:0];
				zero_q    <= !started_n || (sil_n[15:0] >= silence_lim_q);
				ax_q      <= 1'b0;
			end
			if (state_q == ST_P)
				ax_q <= 1'b1;
			if (state_q == ST_OUT && (!out_v_q || m_tready)) begin
				out_v_q  <= 1'b1;
				height_q <= nh_c;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Axis working registers and output word
	always_ff @(posedge clk) begin
		if (state_q == ST_NSQ)
			n_q <= prod_q[21:0];
		if (state_q == ST_SQ1) begin
			s_q    <= '0;
			neg1_q <= sat_lo;
			if (sat_hi)
				a8_q <= 29'sd134217728;
			else if (sat_lo)
				a8_q <= -29'sd134217728;
			else
				a8_q <= $signed({n_q[13:0], 15'd0});
		end
		if (state_q == ST_SQ1W && sq_stat.done)
			s_q <= sq_root[24:0];
		if (state_q == ST_P) begin
			if (ax_q)
				dy_q <= del_v;
			else
				dx_q <= del_v;
		end
		if (state_q == ST_OUT && (!out_v_q || m_tready)) begin
			if (zero_q)
				out_q <= '0;
			else
				out_q <= {to_target(h_ext - 28'(dy_q)), to_target(h_ext - 28'(dx_q)),
					to_target(h_ext + 28'(dy_q)), to_target(h_ext + 28'(dx_q))};
		end
	end

endmodule

### design/ttl_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ttl_pkg for operand widths.
module ttl_mul (
	input  logic                              clk,
	input  logic signed [ttl_pkg::MUL_W-1:0]  op_a,
	input  logic signed [ttl_pkg::MUL_W-1:0]  op_b,
	output logic signed [2*ttl_pkg::MUL_W-1:0] prod_q
);
	import ttl_pkg::*;

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

### design/ttl_sqrt.sv
// Iterative integer square root, two radicand bits per cycle, floor result.
// Depends on ttl_pkg for widths and the status struct.
module ttl_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ttl_pkg::SQRT_W-1:0]       radicand,
	output ttl_pkg::sqrt_stat_t              stat,
	output logic [ttl_pkg::ROOT_W-1:0]       root
);
	import ttl_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 3;

	logic [SQRT_W-1:0] x_q;
	logic [REM_W-1:0]  r_q;
	logic [ROOT_W-1:0] q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [REM_W-1:0]  r_sh, trial;
	logic              ge;

	// One trial subtraction per step
	always_comb begin
		r_sh  = {r_q[REM_W-3:0], x_q[SQRT_W-1 -: 2]};
		trial = {1'b0, q_q, 2'b01};
		ge    = (r_sh >= trial);
	end

	// Control: run for one step per root bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: shift in radicand pairs, build root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[SQRT_W-3:0], 2'b00};
			r_q <= ge ? r_sh - trial : r_sh;
			q_q <= {q_q[ROOT_W-2:0], ge};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign root = q_q;

endmodule
